// File: src/lsf_pkg.sv
package lsf_pkg;

  // longest search term the window can hold
  localparam int TERM_MAX = 16;
  // bytes of one line that take part in matching
  localparam int LINE_MAX = 4096;

  localparam int BYTE_W     = 8;
  localparam int COL_W      = 12;
  localparam int LEN_W      = 5;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int TERM_BYTES = 16;

  localparam int POS_W = $clog2(LINE_MAX + 1);
  localparam int CMP_W = (POS_W > COL_W) ? POS_W : COL_W;
  localparam int IDX_W = (TERM_MAX > 1) ? $clog2(TERM_MAX) : 1;

  localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'd32;

  typedef logic [BYTE_W-1:0]     byte_t;
  typedef logic [COL_W-1:0]      col_t;
  typedef logic [POS_W-1:0]      pos_t;
  typedef logic [CMP_W-1:0]      cmp_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [LEN_W-1:0]      len_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TERM_LOW    = 3'd0,
    REG_TERM_HIGH   = 3'd1,
    REG_TERM_LENGTH = 3'd2,
    REG_MATCH_CASE  = 3'd3,
    REG_BACKWARD    = 3'd4
  } cfg_reg_t;

  // fold A-Z to lower case unless exact compare is selected
  function automatic byte_t fold_byte(input byte_t c, input logic exact);
    byte_t r;
    r = c;
    if (!exact && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

// File: src/line_substring_finder_unit.sv
// Substring finder for one line of text. Bytes of a line arrive one per request,
// with first_of_line on the first byte (which also samples start_column) and
// last_of_line on the final byte; exactly one result (found, match_column) comes
// out for each line, in the cycle after its last byte is taken. The block takes one
// byte per clock: the newest bytes sit in a shift window and all term bytes are
// compared against it in parallel in the same cycle, so the only stall is when a
// finished result is still waiting in the output register and out_ready is low.
// Forward search (search_backward = 0) reports the first match starting at or
// after the start column, backward search the last one starting at or before
// it. With match_case = 0 only A-Z are folded to lower case. term_length is
// clamped to 1..16. Bytes past column 4095 are not matched. Configuration is
// taken at any time (cfg_ready is always high) but should only be written
// while no line is in flight.
module line_substring_finder_unit (
  input  logic                            clk,
  input  logic                            rst,
  // byte requests
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      line_char,
  input  logic [11:0]                     start_column,
  input  logic                            first_of_line,
  input  logic                            last_of_line,
  // line results
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            found,
  output logic [11:0]                     match_column,
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lsf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lsf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // configuration registers
  lsf_pkg::cfg_data_t term_low;
  lsf_pkg::cfg_data_t term_high;
  lsf_pkg::len_t      term_length;
  logic               match_case;
  logic               search_backward;

  // per-line scan state
  lsf_pkg::byte_t     window [lsf_pkg::TERM_MAX];
  lsf_pkg::pos_t      byte_position;
  lsf_pkg::col_t      held_start;
  logic               match_seen;
  lsf_pkg::col_t      best_column;

  // combinational view of one byte request
  logic [2*lsf_pkg::CFG_DATA_W-1:0] term_all;
  lsf_pkg::byte_t     window_next [lsf_pkg::TERM_MAX];
  lsf_pkg::byte_t     term_byte   [lsf_pkg::TERM_MAX];
  lsf_pkg::len_t      len_used;
  lsf_pkg::idx_t      len_m1;
  logic               window_hit;
  lsf_pkg::pos_t      pos_cur;
  lsf_pkg::col_t      start_cur;
  logic               seen_cur;
  lsf_pkg::col_t      best_cur;
  logic               in_range;
  logic               long_enough;
  lsf_pkg::cmp_t      col;
  logic               take;
  logic               match_seen_next;
  lsf_pkg::col_t      best_column_next;
  lsf_pkg::pos_t      byte_position_next;
  logic               in_accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;
  assign term_all  = {term_high, term_low};

  // register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      term_low        <= '0;
      term_high       <= '0;
      term_length     <= lsf_pkg::LEN_W'(1);
      match_case      <= 1'b0;
      search_backward <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lsf_pkg::REG_TERM_LOW:    term_low        <= cfg_data;
        lsf_pkg::REG_TERM_HIGH:   term_high       <= cfg_data;
        lsf_pkg::REG_TERM_LENGTH: term_length     <= cfg_data[lsf_pkg::LEN_W-1:0];
        lsf_pkg::REG_MATCH_CASE:  match_case      <= cfg_data[0];
        lsf_pkg::REG_BACKWARD:    search_backward <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective term length, held to 1..TERM_MAX
  always_comb begin
    if (term_length == '0) begin
      len_used = lsf_pkg::LEN_W'(1);
    end else if (term_length > lsf_pkg::LEN_W'(lsf_pkg::TERM_MAX)) begin
      len_used = lsf_pkg::LEN_W'(lsf_pkg::TERM_MAX);
    end else begin
      len_used = term_length;
    end
    len_m1 = lsf_pkg::IDX_W'(len_used - lsf_pkg::LEN_W'(1));
  end

  // window after shifting in the new byte, and the term as bytes
  always_comb begin
    window_next[0] = line_char;
    for (int i = 1; i < lsf_pkg::TERM_MAX; i++) begin
      window_next[i] = window[i-1];
    end
    for (int k = 0; k < lsf_pkg::TERM_MAX; k++) begin
      term_byte[k] = term_all[k*lsf_pkg::BYTE_W +: lsf_pkg::BYTE_W];
    end
  end

  // parallel compare: term byte k against the byte len-1-k places back
  always_comb begin
    lsf_pkg::idx_t sel;
    window_hit = 1'b1;
    for (int k = 0; k < lsf_pkg::TERM_MAX; k++) begin
      sel = len_m1 - lsf_pkg::IDX_W'(k);
      if (k <= int'(len_m1)) begin
        if (lsf_pkg::fold_byte(window_next[sel], match_case) !=
            lsf_pkg::fold_byte(term_byte[k], match_case)) begin
          window_hit = 1'b0;
        end
      end
    end
  end

  // line state as seen by this byte; a first mark restarts the line
  always_comb begin
    pos_cur   = first_of_line ? '0 : byte_position;
    start_cur = first_of_line ? start_column : held_start;
    seen_cur  = first_of_line ? 1'b0 : match_seen;
    best_cur  = first_of_line ? '0 : best_column;

    in_range    = pos_cur < lsf_pkg::POS_W'(lsf_pkg::LINE_MAX);
    long_enough = (lsf_pkg::CMP_W'(pos_cur) + lsf_pkg::CMP_W'(1)) >=
                  lsf_pkg::CMP_W'(len_used);
    col         = lsf_pkg::CMP_W'(pos_cur) + lsf_pkg::CMP_W'(1) -
                  lsf_pkg::CMP_W'(len_used);

    take = 1'b0;
    if (in_range && long_enough && window_hit) begin
      if (search_backward) begin
        // keep moving forward while still at or before the start
        take = col <= lsf_pkg::CMP_W'(start_cur);
      end else begin
        // first qualifying match only
        take = !seen_cur && (col >= lsf_pkg::CMP_W'(start_cur));
      end
    end

    match_seen_next    = seen_cur || take;
    best_column_next   = take ? lsf_pkg::COL_W'(col) : best_cur;
    byte_position_next = in_range ? pos_cur + lsf_pkg::POS_W'(1) : pos_cur;
  end

  // scan state update
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      held_start    <= '0;
      match_seen    <= 1'b0;
      best_column   <= '0;
      for (int i = 0; i < lsf_pkg::TERM_MAX; i++) begin
        window[i] <= '0;
      end
    end else if (in_accept) begin
      held_start <= start_cur;
      if (in_range) begin
        for (int i = 0; i < lsf_pkg::TERM_MAX; i++) begin
          window[i] <= window_next[i];
        end
      end
      if (last_of_line) begin
        // line closed: next byte starts a fresh line at column 0
        byte_position <= '0;
        match_seen    <= 1'b0;
        best_column   <= '0;
      end else begin
        byte_position <= byte_position_next;
        match_seen    <= match_seen_next;
        best_column   <= best_column_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && last_of_line) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && last_of_line) begin
      found        <= match_seen_next;
      match_column <= match_seen_next ? best_column_next : '0;
    end
  end

endmodule

// File: src/lsf_checker.sv
module lsf_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [7:0]                      line_char,
  input logic [11:0]                     start_column,
  input logic                            first_of_line,
  input logic                            last_of_line,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            found,
  input logic [11:0]                     match_column,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [lsf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [lsf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(found) && $stable(match_column))
    else $error("result changed while stalled");

  // a line end always produces a result next cycle
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_of_line |=> out_valid)
    else $error("line end without result");

  // a byte inside a line never creates a result
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !(in_valid && in_ready && last_of_line) |=> !out_valid)
    else $error("result without line end");

  // no match reports column zero
  a_column_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> match_column == '0)
    else $error("nonzero column without match");

  // a waiting result must not be overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken over a waiting result");

endmodule

bind line_substring_finder_unit lsf_checker u_lsf_checker (.*);

// File: bench/lsf_bench_pkg.sv
package lsf_bench_pkg;
  import lsf_pkg::*;

  typedef struct packed {
    logic found;
    col_t column;
  } line_result_t;

  // tracks register contents and line state, predicts one result per line end
  class line_match_scoreboard;
    cfg_data_t term_lo;
    cfg_data_t term_hi;
    len_t term_size;
    logic exact;
    logic backward;

    byte_t window [TERM_MAX];
    int unsigned position;
    col_t held_start;
    logic seen;
    col_t best;

    line_result_t pending_lines[$];
    int unsigned mismatches;
    int unsigned lines_checked;
    int unsigned matches_seen;

    function new();
      term_lo = '0;
      term_hi = '0;
      term_size = LEN_W'(1);
      exact = 1'b0;
      backward = 1'b0;
      foreach (window[k]) window[k] = '0;
      position = 0;
      held_start = '0;
      seen = 1'b0;
      best = '0;
      mismatches = 0;
      lines_checked = 0;
      matches_seen = 0;
    endfunction

    function void set_register(cfg_reg_t idx, cfg_data_t data);
      case (idx)
        REG_TERM_LOW:    term_lo = data;
        REG_TERM_HIGH:   term_hi = data;
        REG_TERM_LENGTH: term_size = data[LEN_W-1:0];
        REG_MATCH_CASE:  exact = data[0];
        REG_BACKWARD:    backward = data[0];
        default: ;
      endcase
    endfunction

    function int unsigned used_length();
      if (term_size == 0) return 1;
      if (term_size > TERM_MAX) return TERM_MAX;
      return 32'(term_size);
    endfunction

    function byte_t term_at(int unsigned k);
      return (k < 8) ? term_lo[k*8 +: 8] : term_hi[(k-8)*8 +: 8];
    endfunction

    function byte_t fold_case(byte_t c);
      if (!exact && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return c + CASE_OFFSET;
      return c;
    endfunction

    function void note_request(byte_t ch, col_t start, logic first, logic last);
      int unsigned len;
      int unsigned col;
      int k;
      bit hit;
      line_result_t res;
      len = used_length();
      if (first) begin
        position = 0;
        held_start = start;
        seen = 1'b0;
        best = '0;
      end
      if (position < LINE_MAX) begin
        for (k = TERM_MAX - 1; k > 0; k--) window[k] = window[k-1];
        window[0] = ch;
        if (position + 1 >= len) begin
          hit = 1'b1;
          for (k = 0; k < len; k++) begin
            if (fold_case(window[len-1-k]) != fold_case(term_at(k))) hit = 1'b0;
          end
          if (hit) begin
            col = position + 1 - len;
            if (backward) begin
              if (col <= held_start) begin
                seen = 1'b1;
                best = col_t'(col);
              end
            end else if (!seen && col >= held_start) begin
              seen = 1'b1;
              best = col_t'(col);
            end
          end
        end
        position++;
      end
      if (last) begin
        res.found = seen;
        res.column = seen ? best : '0;
        pending_lines.push_back(res);
        if (seen) matches_seen++;
        position = 0;
        seen = 1'b0;
        best = '0;
      end
    endfunction

    function void flag(string what, line_result_t want, logic found, col_t column);
      mismatches++;
      if (mismatches <= 10) begin
        $display("line result %0d: %s: expected found=%0b column=%0d, got found=%0b column=%0d",
                 lines_checked, what, want.found, want.column, found, column);
      end
    endfunction

    function void check_result(logic found, col_t column);
      line_result_t want;
      lines_checked++;
      if (pending_lines.size() == 0) begin
        want = '0;
        flag("no line pending", want, found, column);
        return;
      end
      want = pending_lines.pop_front();
      if (found !== want.found || column !== want.column) begin
        flag("wrong result", want, found, column);
      end
    endfunction
  endclass

endpackage

// File: bench/line_substring_finder_unit_test.sv
module line_substring_finder_unit_test;
  import lsf_pkg::*;
  import lsf_bench_pkg::*;

  // clock, reset and every block input start at known values
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  byte_t line_char = '0;
  col_t start_column = '0;
  logic first_of_line = 1'b0;
  logic last_of_line = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic found;
  col_t match_column;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  cfg_data_t cfg_data = '0;

  // when set, neither side inserts bubbles
  logic steady = 1'b0;

  line_match_scoreboard sb;
  byte_t line_buf[$];
  int unsigned bytes_sent = 0;
  int unsigned writes = 0;
  int unsigned settings_used = 0;

  line_substring_finder_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .line_char     (line_char),
    .start_column  (start_column),
    .first_of_line (first_of_line),
    .last_of_line  (last_of_line),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .found         (found),
    .match_column  (match_column),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // hard stop in case the block hangs or drops a result
  initial begin
    #800000;
    $display("end of test: mismatches");
    $finish;
  end

  // result side: sample at the edge, then pick the next ready value
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        sb.check_result(found, match_column);
      end
      out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 22);
    end
  end

  // one byte request; valid stays up afterwards until the next call decides
  task automatic send_byte(byte_t ch, col_t start, logic first, logic last);
    if (!steady && $urandom_range(0, 99) < 22) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    line_char <= ch;
    start_column <= start;
    first_of_line <= first;
    last_of_line <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_request(ch, start, first, last);
    bytes_sent++;
  endtask

  // hold off the sender until every line result is back, plus a little slack
  // for the output register
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending_lines.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // register writes only happen with nothing in flight
  task automatic write_register(cfg_reg_t idx, cfg_data_t data);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, data);
    cfg_valid <= 1'b0;
    writes++;
  endtask

  // the start column only counts on the first byte; later bytes carry noise there
  task automatic send_line(col_t start, bit with_first);
    int unsigned i;
    for (i = 0; i < line_buf.size(); i++) begin
      send_byte(line_buf[i], (i == 0) ? start : col_t'($urandom_range(0, 4095)),
                with_first && i == 0, i == line_buf.size() - 1);
    end
  endtask

  task automatic load_text(string s);
    line_buf.delete();
    foreach (s[i]) line_buf.push_back(byte_t'(s[i]));
  endtask

  // small alphabet so terms show up often, plus bytes around the fold range
  function automatic byte_t pick_char();
    int unsigned r;
    r = $urandom_range(0, 15);
    case (r)
      0, 1, 2, 3: return byte_t'(8'h61 + r);
      4, 5, 6, 7: return byte_t'(8'h41 + r - 4);
      8:  return 8'h40;
      9:  return 8'h5B;
      10: return 8'h60;
      11: return 8'h7B;
      12: return CHAR_UPPER_Z;
      13: return 8'h7A;
      14: return 8'h00;
      default: return byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  // random text with a few copies of the current term dropped in, with
  // random case flips when case folding is on
  task automatic make_line(int unsigned len);
    int unsigned tlen;
    int unsigned at;
    int unsigned k;
    byte_t c;
    byte_t up;
    line_buf.delete();
    repeat (len) line_buf.push_back(pick_char());
    tlen = sb.used_length();
    if (len >= tlen && $urandom_range(0, 9) < 7) begin
      repeat ($urandom_range(1, 3)) begin
        at = $urandom_range(0, len - tlen);
        for (k = 0; k < tlen; k++) begin
          c = sb.term_at(k);
          up = c & ~CASE_OFFSET;
          if (!sb.exact && up >= CHAR_UPPER_A && up <= CHAR_UPPER_Z && $urandom_range(0, 1)) begin
            c = c ^ CASE_OFFSET;
          end
          line_buf[at + k] = c;
        end
      end
    end
  endtask

  function automatic cfg_data_t term_word(bit bytes_mode);
    cfg_data_t w;
    int k;
    if (bytes_mode) return {$urandom, $urandom};
    for (k = 0; k < 8; k++) w[k*8 +: 8] = pick_char();
    return w;
  endfunction

  // new register setting; the first two settings hit the term extremes
  task automatic pick_settings();
    cfg_data_t lo;
    cfg_data_t hi;
    cfg_data_t len;
    int unsigned r;
    lo = term_word(settings_used % 4 == 3);
    hi = term_word(settings_used % 4 == 2);
    r = $urandom_range(0, 9);
    if (r == 0) len = 1;
    else if (r == 1) len = 16;
    else if (r == 2) len = $urandom_range(0, 31);
    else len = $urandom_range(1, 5);
    if (settings_used == 0) begin
      lo = '1;
      hi = '1;
      len = 16;
    end else if (settings_used == 1) begin
      lo = '0;
      hi = '0;
      len = 1;
    end
    write_register(REG_TERM_LOW, lo);
    write_register(REG_TERM_HIGH, hi);
    write_register(REG_TERM_LENGTH, len);
    write_register(REG_MATCH_CASE, cfg_data_t'($urandom_range(0, 1)));
    write_register(REG_BACKWARD, cfg_data_t'($urandom_range(0, 1)));
    settings_used++;
  endtask

  initial begin
    int unsigned base;
    int unsigned len;
    int unsigned r;
    col_t start;

    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: term "aB", case folded, forward search
    write_register(REG_TERM_LOW, 64'h4261);
    write_register(REG_TERM_HIGH, '0);
    write_register(REG_TERM_LENGTH, 64'd2);
    write_register(REG_MATCH_CASE, 64'd0);
    write_register(REG_BACKWARD, 64'd0);
    load_text("xAbab");
    send_line(12'd0, 1'b1);
    // start column past the only match
    load_text("ab");
    send_line(12'd3, 1'b1);

    // backward from a start column beyond the line end
    write_register(REG_BACKWARD, 64'd1);
    load_text("abAB");
    send_line(12'd4095, 1'b1);
    // one-byte line, shorter than the term
    load_text("a");
    send_line(12'd0, 1'b1);
    // line without its first mark keeps the old start column
    load_text("xab");
    send_line(12'd7, 1'b0);
    // first mark arrives again in the middle of a line
    send_byte(8'h7A, 12'd5, 1'b1, 1'b0);
    send_byte(8'h7A, 12'd9, 1'b0, 1'b0);
    load_text("ab");
    send_line(12'd2, 1'b1);

    // zero term byte, length zero taken as one, exact compare
    write_register(REG_MATCH_CASE, 64'd1);
    write_register(REG_TERM_LENGTH, 64'd0);
    write_register(REG_TERM_LOW, 64'd0);
    line_buf.delete();
    line_buf.push_back(8'h00);
    line_buf.push_back(8'hFF);
    line_buf.push_back(8'h41);
    line_buf.push_back(8'h00);
    send_line(12'd3, 1'b1);

    // random settings, each followed by a batch of lines
    base = bytes_sent;
    while (bytes_sent - base < 1900) begin
      pick_settings();
      repeat ($urandom_range(8, 20)) begin
        steady <= (bytes_sent - base >= 500 && bytes_sent - base < 900);
        r = $urandom_range(0, 9);
        len = (r == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
        make_line(len);
        r = $urandom_range(0, 9);
        if (r < 6) start = col_t'($urandom_range(0, len + 1));
        else if (r == 6) start = '0;
        else if (r == 7) start = '1;
        else if (r == 8) start = col_t'($urandom_range(0, 4095));
        else start = col_t'(len - 1);
        r = $urandom_range(0, 19);
        if (r == 1) begin
          // a broken fragment that the next first mark throws away
          repeat ($urandom_range(1, 3)) begin
            send_byte(pick_char(), col_t'($urandom_range(0, 4095)), 1'b1, 1'b0);
          end
        end
        send_line(start, r != 0);
      end
    end
    steady <= 1'b0;

    // wait for the tail of the results, then settle
    drain_results();
    repeat (8) @(posedge clk);

    $display("checked %0d line results (%0d with a match) over %0d bytes",
             sb.lines_checked, sb.matches_seen, bytes_sent);
    $display("%0d register writes in %0d random settings, term lengths 1 to 16",
             writes, settings_used);
    if (sb.mismatches == 0 && sb.pending_lines.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: files.f
src/lsf_pkg.sv
src/line_substring_finder_unit.sv
src/lsf_checker.sv
bench/lsf_bench_pkg.sv
bench/line_substring_finder_unit_test.sv
